[hw/rtl/assert_macros.svh]
// Assertion macros shared by the encoder and button input RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define REC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define REC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

[hw/rtl/rec_pkg.sv]
// Types, constants and helper functions for the rotary encoder and button input block.
`default_nettype none
package rec_pkg;

   // Saturation limits and time width.
   localparam int COUNT_LIMIT   = 64;
   localparam int PENDING_LIMIT = 64;
   localparam int TIME_BITS     = 32;

   // Width of the signed step count and pending delta.
   localparam int CNT_W = 8;
   // Width of the divider operands (count magnitude and detent size).
   localparam int DVD_W = 7;
   // One quotient bit per divider iteration.
   localparam int DIV_STEPS = DVD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef logic signed [CNT_W-1:0] count_type;

   localparam count_type COUNT_MAX   = CNT_W'(COUNT_LIMIT);
   localparam count_type PENDING_MAX = CNT_W'(PENDING_LIMIT);

   // Command codes.
   typedef enum logic [1:0] {
      CMD_SAMPLE     = 2'd0,
      CMD_POLL       = 2'd1,
      CMD_READ_DELTA = 2'd2,
      CMD_READ_EVENT = 2'd3
   } cmd_type;

   // Button event codes.
   typedef enum logic [1:0] {
      EVT_NONE  = 2'd0,
      EVT_SHORT = 2'd1,
      EVT_LONG  = 2'd2
   } btn_event_type;

   // Register indexes.
   localparam logic [2:0] REG_STEPS_PER_DETENT  = 3'd0;
   localparam logic [2:0] REG_REVERSE_DIRECTION = 3'd1;
   localparam logic [2:0] REG_USE_ALT_BUTTON    = 3'd2;
   localparam logic [2:0] REG_DEBOUNCE_MS       = 3'd3;
   localparam logic [2:0] REG_LONG_PRESS_MS     = 3'd4;

   // Status from the serial divider to the sequencer.
   typedef struct packed {
      logic             done;
      logic             nonzero;
      logic [DVD_W-1:0] rem;
   } div_status_type;

   // Quadrature transition table: previous phase and new phase give the step.
   function automatic logic signed [1:0] quad_step(input logic [1:0] prev,
                                                   input logic [1:0] cur);
      logic signed [1:0] mv;
      case ({prev, cur})
         4'd1, 4'd7, 4'd8, 4'd14: mv = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: mv = 2'sd1;
         default: mv = 2'sd0;
      endcase
      return mv;
   endfunction

   // Adds a unit step and saturates at plus or minus lim.
   function automatic count_type sat_add(input count_type a, input logic signed [1:0] b,
                                         input count_type lim);
      logic signed [CNT_W:0] s;
      logic signed [CNT_W:0] hi;
      logic signed [CNT_W:0] lo;
      count_type             r;
      hi = signed'({lim[CNT_W-1], lim});
      lo = -hi;
      s  = signed'({a[CNT_W-1], a}) + signed'({{(CNT_W-1){b[1]}}, b});
      if (s > hi) begin
         r = lim;
      end else if (s < lo) begin
         r = lo[CNT_W-1:0];
      end else begin
         r = s[CNT_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/rec_div.sv]
// Restoring serial divider: one quotient bit per cycle, keeps the remainder.
`default_nettype none
module rec_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [rec_pkg::DVD_W-1:0] dividend,
   input  wire logic [rec_pkg::DVD_W-1:0] divisor,
   output rec_pkg::div_status_type        status
);
   import rec_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 nz_ff, nz_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [DVD_W-1:0]     div_ff, div_in;
   logic [DVD_W-1:0]     rem_ff, rem_in;
   logic [DVD_W:0]       rem_sh;
   logic [DVD_W+1:0]     diff;
   logic                 ge;

   // One trial subtraction per cycle.
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, div_ff};
      ge      = !diff[DVD_W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      nz_in   = nz_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         nz_in   = 1'b0;
         cnt_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVD_W-1:0] : rem_sh[DVD_W-1:0];
         nz_in  = nz_ff | ge;
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      nz_ff  <= nz_in;
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign status.done    = done_ff;
   assign status.nonzero = nz_ff;
   assign status.rem     = rem_ff;

endmodule
`default_nettype wire

[hw/rtl/rec_btn.sv]
// Button debounce and short or long press detection with a latched event.
`default_nettype none
`include "assert_macros.svh"
module rec_btn (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          poll,
   input  wire logic                          clear_event,
   input  wire logic                          raw,
   input  wire logic [rec_pkg::TIME_BITS-1:0] now,
   input  wire logic [15:0]                   debounce_ms,
   input  wire logic [15:0]                   long_press_ms,
   output rec_pkg::btn_event_type             event_value
);
   import rec_pkg::*;

   logic                 raw_prev_ff, raw_prev_in;
   logic                 stable_ff, stable_in;
   logic                 held_ff, held_in;
   logic                 lr_ff, lr_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   btn_event_type        evt_ff, evt_in;
   logic [TIME_BITS-1:0] deb_elapsed;
   logic [TIME_BITS-1:0] long_elapsed;
   logic                 flip;

   // Next state for a poll; a read of the event clears it.
   always_comb begin
      raw_prev_in = raw_prev_ff;
      stable_in   = stable_ff;
      held_in     = held_ff;
      lr_in       = lr_ff;
      last_in     = last_ff;
      start_in    = start_ff;
      evt_in      = evt_ff;
      if (raw != raw_prev_ff) begin
         raw_prev_in = raw;
         last_in     = now;
      end
      deb_elapsed = now - last_in;
      flip = (deb_elapsed >= TIME_BITS'(debounce_ms)) && (raw != stable_ff);
      if (flip) begin
         stable_in = raw;
         if (raw) begin
            held_in  = 1'b1;
            lr_in    = 1'b0;
            start_in = now;
         end else if (held_ff) begin
            held_in = 1'b0;
            if (!lr_ff) begin
               evt_in = EVT_SHORT;
            end
            lr_in = 1'b0;
         end
      end
      long_elapsed = now - start_in;
      if (held_in && !lr_in && (long_elapsed >= TIME_BITS'(long_press_ms))) begin
         lr_in  = 1'b1;
         evt_in = EVT_LONG;
      end
      if (clear_event) begin
         evt_in = EVT_NONE;
      end
   end

   // State registers; the time stamps reset to zero as well.
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_prev_ff <= 1'b0;
         stable_ff   <= 1'b0;
         held_ff     <= 1'b0;
         lr_ff       <= 1'b0;
         last_ff     <= '0;
         start_ff    <= '0;
         evt_ff      <= EVT_NONE;
      end else if (poll || clear_event) begin
         raw_prev_ff <= poll ? raw_prev_in : raw_prev_ff;
         stable_ff   <= poll ? stable_in : stable_ff;
         held_ff     <= poll ? held_in : held_ff;
         lr_ff       <= poll ? lr_in : lr_ff;
         last_ff     <= poll ? last_in : last_ff;
         start_ff    <= poll ? start_in : start_ff;
         evt_ff      <= evt_in;
      end
   end

   assign event_value = evt_ff;

   // The long-press flag is only ever set while the button is held.
   `REC_ASSERT_IMPLY(a_long_needs_held, clock, reset, lr_ff, held_ff)

endmodule
`default_nettype wire

[hw/rtl/rotary_encoder_button_input_top.sv]
// Top level of the rotary encoder and debounced button input block.
`default_nettype none
`include "assert_macros.svh"
// One beat on the request channel carries one command and gives exactly one
// response beat. A pin sample, a delta read and an event read pass from
// acceptance through the done state to the response register. A poll first
// runs the detent division of the step count in a restoring serial divider
// that produces one quotient bit per cycle; the result is then folded into
// the count and the pending delta, and the response register is loaded.
// The request side is stalled while an item is in flight; a finished response
// may wait on a stalled response channel while the next request is accepted.
// Configuration registers sit at byte addresses 0, 4, 8, 12 and 16; the user
// must write them only while the block is idle, which the block does not enforce.
module rotary_encoder_button_input_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request channel.
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic                          req_pin_a,
   input  wire logic                          req_pin_b,
   input  wire logic                          req_button_level,
   input  wire logic                          req_alt_button_level,
   input  wire logic [31:0]                   req_now_ms,
   // Response channel.
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [1:0]                  rsp_delta,
   output logic [1:0]                         rsp_button_event,
   // Configuration port.
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [4:0]                    csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import rec_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [6:0]        steps_ff;
   logic              reverse_ff;
   logic              use_alt_ff;
   logic [15:0]       debounce_ff;
   logic [15:0]       long_press_ff;
   logic [1:0]        phase_ff, phase_in;
   count_type         count_ff, count_in;
   count_type         pending_ff, pending_in;
   logic signed [1:0] res_delta_ff, res_delta_in;
   btn_event_type     res_event_ff, res_event_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [1:0] rsp_delta_ff;
   logic [1:0]        rsp_event_ff;

   cmd_type           cmd;
   logic              accept;
   logic              out_free;
   logic              csr_write;
   logic [2:0]        csr_index;
   logic [1:0]        phase_new;
   logic signed [1:0] mv;
   logic signed [1:0] rd_delta;
   count_type         count_mag;
   count_type         rem_signed;
   logic [DVD_W-1:0]  divisor;
   logic              btn_raw;
   div_status_type    div_status;
   btn_event_type     btn_event;

   assign cmd       = cmd_type'(req_cmd);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Configuration writes and reads.
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff      <= 7'd4;
         reverse_ff    <= 1'b0;
         use_alt_ff    <= 1'b0;
         debounce_ff   <= 16'd18;
         long_press_ff <= 16'd700;
      end else if (csr_write) begin
         case (csr_index)
            REG_STEPS_PER_DETENT:  steps_ff      <= csr_pwdata[6:0];
            REG_REVERSE_DIRECTION: reverse_ff    <= csr_pwdata[0];
            REG_USE_ALT_BUTTON:    use_alt_ff    <= csr_pwdata[0];
            REG_DEBOUNCE_MS:       debounce_ff   <= csr_pwdata[15:0];
            REG_LONG_PRESS_MS:     long_press_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_STEPS_PER_DETENT:  csr_prdata = {25'd0, steps_ff};
         REG_REVERSE_DIRECTION: csr_prdata = {31'd0, reverse_ff};
         REG_USE_ALT_BUTTON:    csr_prdata = {31'd0, use_alt_ff};
         REG_DEBOUNCE_MS:       csr_prdata = {16'd0, debounce_ff};
         REG_LONG_PRESS_MS:     csr_prdata = {16'd0, long_press_ff};
         default:               csr_prdata = '0;
      endcase
   end

   // Divider operands: count magnitude over the detent size, zero acting as one.
   assign count_mag = count_ff[CNT_W-1] ? CNT_W'(-count_ff) : count_ff;
   assign divisor   = (steps_ff == '0) ? DVD_W'(1) : steps_ff;

   rec_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && (cmd == CMD_POLL)),
      .dividend (count_mag[DVD_W-1:0]),
      .divisor  (divisor),
      .status   (div_status)
   );

   // Button debounce runs on the poll beat itself.
   assign btn_raw = !req_button_level || (use_alt_ff && !req_alt_button_level);

   rec_btn u_btn (
      .clock         (clock),
      .reset         (reset),
      .poll          (accept && (cmd == CMD_POLL)),
      .clear_event   (accept && (cmd == CMD_READ_EVENT)),
      .raw           (btn_raw),
      .now           (req_now_ms[TIME_BITS-1:0]),
      .debounce_ms   (debounce_ff),
      .long_press_ms (long_press_ff),
      .event_value   (btn_event)
   );

   // Quadrature decode of the sampled pins.
   assign phase_new = {req_pin_a, req_pin_b};
   assign mv        = reverse_ff ? -quad_step(phase_ff, phase_new)
                                 : quad_step(phase_ff, phase_new);

   // Unit step handed out by a delta read.
   assign rd_delta = (pending_ff > 0) ? 2'sd1 : ((pending_ff < 0) ? -2'sd1 : 2'sd0);

   // Remainder carries the sign of the count (truncation toward zero).
   assign rem_signed = count_ff[CNT_W-1] ? CNT_W'(-signed'({1'b0, div_status.rem}))
                                         : signed'({1'b0, div_status.rem});

   // Sequencer and item state.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      pending_in   = pending_ff;
      res_delta_in = res_delta_ff;
      res_event_in = res_event_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_delta_in = 2'sd0;
               res_event_in = EVT_NONE;
               state_in     = ST_DONE;
               case (cmd)
                  CMD_SAMPLE: begin
                     phase_in = phase_new;
                     if (mv != 2'sd0) begin
                        count_in = sat_add(count_ff, mv, COUNT_MAX);
                     end
                  end
                  CMD_POLL: begin
                     state_in = ST_DIV;
                  end
                  CMD_READ_DELTA: begin
                     res_delta_in = rd_delta;
                     pending_in   = pending_ff - count_type'(rd_delta);
                  end
                  CMD_READ_EVENT: begin
                     res_event_in = btn_event;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               count_in = rem_signed;
               if (div_status.nonzero) begin
                  pending_in = sat_add(pending_ff,
                                       count_ff[CNT_W-1] ? -2'sd1 : 2'sd1, PENDING_MAX);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 2'd0;
         count_ff     <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload and response register.
   always_ff @(posedge clock) begin
      res_delta_ff <= res_delta_in;
      res_event_ff <= res_event_in;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_delta_ff <= res_delta_ff;
         rsp_event_ff <= res_event_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_delta        = rsp_delta_ff;
   assign rsp_button_event = rsp_event_ff;

   // An accepted beat always leaves the idle state.
   `REC_ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != ST_IDLE)
   // The divider only finishes while the sequencer waits on it.
   `REC_ASSERT_IMPLY(a_div_done_in_div, clock, reset, div_status.done, state_ff == ST_DIV)
   // Count and pending delta stay within their saturation limits.
   `REC_ASSERT_IMPLY(a_limits, clock, reset, 1'b1,
      (count_ff <= COUNT_MAX) && (count_ff >= -COUNT_MAX) &&
      (pending_ff <= PENDING_MAX) && (pending_ff >= -PENDING_MAX))

endmodule
`default_nettype wire
